// ===== src/hssc_pkg.sv =====
package hssc_pkg;

   // Configuration register indexes
   localparam logic REG_DRIVE_ENABLE = 1'b0;
   localparam logic REG_PWM_PERIOD   = 1'b1;

   // Field widths
   localparam int SETPOINT_W = 16;
   localparam int PERIOD_W   = 12;
   localparam int DUTY_W     = 12;
   localparam int POS_W      = 3;
   localparam int DRIVE_W    = 11;
   localparam int SPEED_W    = 24;
   localparam int ACC_W      = 20;

   // Filter corner: accumulator holds about setpoint << LPF_SHIFT
   localparam int LPF_SHIFT = 8;

   // Drive limit and duty floor
   localparam int DRIVE_LIMIT = 1000;
   localparam int DUTY_FLOOR  = 10;

   // Packed stream widths, whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 80;

   // Six-step positions
   localparam logic [POS_W-1:0] POS_NONE = 3'd0;
   localparam logic [POS_W-1:0] POS_1    = 3'd1;
   localparam logic [POS_W-1:0] POS_2    = 3'd2;
   localparam logic [POS_W-1:0] POS_3    = 3'd3;
   localparam logic [POS_W-1:0] POS_4    = 3'd4;
   localparam logic [POS_W-1:0] POS_5    = 3'd5;
   localparam logic [POS_W-1:0] POS_6    = 3'd6;

   typedef logic signed [DRIVE_W-1:0] drive_type;

   // Hall code (a + 2b + 4c) to six-step position; codes 0 and 7 are invalid
   function automatic logic [POS_W-1:0] hall_position(input logic [2:0] code);
      logic [POS_W-1:0] pos;
      unique case (code)
         3'd1:    pos = POS_3;
         3'd2:    pos = POS_5;
         3'd3:    pos = POS_4;
         3'd4:    pos = POS_1;
         3'd5:    pos = POS_2;
         3'd6:    pos = POS_6;
         default: pos = POS_NONE;
      endcase
      return pos;
   endfunction

   // Offset by half the period, clamp to floor .. max(period - floor, floor)
   function automatic logic [DUTY_W-1:0] phase_duty(input drive_type drive,
                                                    input logic [PERIOD_W-1:0] period);
      logic signed [PERIOD_W+1:0] hi;
      logic signed [PERIOD_W+1:0] val;
      logic signed [PERIOD_W+1:0] res;
      hi  = $signed({2'b00, period}) - (PERIOD_W+2)'(DUTY_FLOOR);
      val = (PERIOD_W+2)'(drive) + $signed({3'b000, period[PERIOD_W-1:1]});
      if (hi < (PERIOD_W+2)'(DUTY_FLOOR)) begin
         hi = (PERIOD_W+2)'(DUTY_FLOOR);
      end
      res = val;
      if (val < (PERIOD_W+2)'(DUTY_FLOOR)) begin
         res = (PERIOD_W+2)'(DUTY_FLOOR);
      end
      if (res > hi) begin
         res = hi;
      end
      return res[DUTY_W-1:0];
   endfunction

endpackage

// ===== src/hall_six_step_commutator.sv =====
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_tvalid/req_tready | req_tdata: hall code, drive setpoint
// rsp      | out       | rsp_tvalid/rsp_tready | rsp_tdata: duties, enable, position,
//          |           |                       |            filtered drive, speed period
// csr      | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One transaction per clock sustained while rsp is not stalled; a transaction taken on req
// passes through the input register, then the result register, where filter and tick state
// update, and is then offered on rsp. The result register loads whenever it is
// free or being taken, so a stall on rsp backs up into req_tready only once both are full.
// Synchronous reset clears stage valids and state; pwm_period resets to 2000.
module hall_six_step_commutator #(
   parameter int SPEED_COUNTER_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] hall_a, [1] hall_b, [2] hall_c, [18:3] drive_setpoint, [23:19] zero
   input  logic [hssc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] duty_y, [23:12] duty_b, [35:24] duty_g, [36] outputs_on,
   // [39:37] rotor_position, [50:40] filtered_drive, [74:51] speed_period, [79:75] zero
   output logic [hssc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [hssc_pkg::PERIOD_W-1:0]       csr_data
);
   import hssc_pkg::*;

   localparam int CNT_W = SPEED_COUNTER_BITS;
   localparam int CAP_W = (CNT_W > SPEED_W) ? CNT_W : SPEED_W;

   // Configuration
   logic                  enable_ff;
   logic [PERIOD_W-1:0]   period_ff;

   // Input stage
   logic                  s1_valid_ff;
   logic [2:0]            s1_hall_ff;
   logic signed [SETPOINT_W-1:0] s1_setpoint_ff;

   // Result stage
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // Running state
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]        prev_pos_ff, prev_pos_in;
   logic [CNT_W-1:0]        tick_ff, tick_in;
   logic [CNT_W-1:0]        captured_ff, captured_in;

   logic                    advance;
   logic [POS_W-1:0]        pos;
   drive_type               sp_clamp;
   logic signed [ACC_W+1:0] acc_sum;
   logic signed [ACC_W-1:0] acc_sat;
   logic signed [ACC_W-1:0] acc_shifted;
   drive_type               filt;
   drive_type               neg_filt;
   drive_type               drv_y, drv_b, drv_g;
   logic [DUTY_W-1:0]       duty_y, duty_b, duty_g;
   logic [CAP_W-1:0]        cap_ext;
   logic [SPEED_W-1:0]      speed;
   logic                    entry;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         period_ff <= PERIOD_W'(2000);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DRIVE_ENABLE: enable_ff <= csr_data[0];
            REG_PWM_PERIOD:   period_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_hall_ff     <= req_tdata[2:0];
         s1_setpoint_ff <= $signed(req_tdata[18:3]);
      end
   end

   // Position decode and setpoint clamp
   always_comb begin
      pos = hall_position(s1_hall_ff);
      if (s1_setpoint_ff > SETPOINT_W'(DRIVE_LIMIT)) begin
         sp_clamp = DRIVE_W'(DRIVE_LIMIT);
      end else if (s1_setpoint_ff < -SETPOINT_W'(DRIVE_LIMIT)) begin
         sp_clamp = -DRIVE_W'(DRIVE_LIMIT);
      end else begin
         sp_clamp = s1_setpoint_ff[DRIVE_W-1:0];
      end
   end

   // Shift low-pass filter with saturation
   always_comb begin
      acc_sum = (ACC_W+2)'(acc_ff) - (ACC_W+2)'(acc_ff >>> LPF_SHIFT)
              + (ACC_W+2)'(sp_clamp);
      if (acc_sum > (ACC_W+2)'((1 << (ACC_W-1)) - 1)) begin
         acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
      end else if (acc_sum < -(ACC_W+2)'(1 << (ACC_W-1))) begin
         acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
      acc_in = enable_ff ? acc_sat : acc_ff;
      acc_shifted = acc_in >>> LPF_SHIFT;
      if (acc_shifted > ACC_W'(DRIVE_LIMIT)) begin
         filt = DRIVE_W'(DRIVE_LIMIT);
      end else if (acc_shifted < -ACC_W'(DRIVE_LIMIT)) begin
         filt = -DRIVE_W'(DRIVE_LIMIT);
      end else begin
         filt = acc_shifted[DRIVE_W-1:0];
      end
      neg_filt = -filt;
   end

   // Commutation: one phase high, one low, one floating at midpoint
   always_comb begin
      drv_y = '0;
      drv_b = '0;
      drv_g = '0;
      unique case (pos)
         POS_1: begin drv_b = filt;     drv_g = neg_filt; end
         POS_2: begin drv_y = neg_filt; drv_b = filt;     end
         POS_3: begin drv_y = neg_filt; drv_g = filt;     end
         POS_4: begin drv_b = neg_filt; drv_g = filt;     end
         POS_5: begin drv_y = filt;     drv_b = neg_filt; end
         POS_6: begin drv_y = filt;     drv_g = neg_filt; end
         default: ;
      endcase
      if (enable_ff) begin
         duty_y = phase_duty(drv_y, period_ff);
         duty_b = phase_duty(drv_b, period_ff);
         duty_g = phase_duty(drv_g, period_ff);
      end else begin
         duty_y = '0;
         duty_b = '0;
         duty_g = '0;
      end
   end

   // Speed measurement between entries into position 1
   always_comb begin
      entry       = (prev_pos_ff != POS_1) && (pos == POS_1);
      prev_pos_in = prev_pos_ff;
      tick_in     = tick_ff;
      captured_in = captured_ff;
      if (enable_ff) begin
         prev_pos_in = pos;
         if (entry) begin
            captured_in = tick_ff;
            tick_in     = CNT_W'(1);
         end else if (tick_ff != {CNT_W{1'b1}}) begin
            tick_in = tick_ff + CNT_W'(1);
         end
      end
      cap_ext = CAP_W'(captured_in);
      if (cap_ext > CAP_W'({SPEED_W{1'b1}})) begin
         speed = {SPEED_W{1'b1}};
      end else begin
         speed = cap_ext[SPEED_W-1:0];
      end
      rsp_data_in = {5'b0, speed, filt, pos, enable_ff, duty_g, duty_b, duty_y};
   end

   // Result register and state update
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         prev_pos_ff  <= POS_NONE;
         tick_ff      <= '0;
         captured_ff  <= '0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            acc_ff      <= acc_in;
            prev_pos_ff <= prev_pos_in;
            tick_ff     <= tick_in;
            captured_ff <= captured_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import hssc_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ACC_HI       = (1 << (ACC_W - 1)) - 1;
   localparam int ACC_LO       = -(1 << (ACC_W - 1));

   // One input transaction, last field in the lowest bits
   typedef struct packed {
      logic signed [SETPOINT_W-1:0] setpoint;
      logic                         hall_c;
      logic                         hall_b;
      logic                         hall_a;
   } hall_sample_type;

   localparam int SAMPLE_W = $bits(hall_sample_type);

   // One result transaction, last field in the lowest bits
   typedef struct packed {
      logic [SPEED_W-1:0]        speed_period;
      logic signed [DRIVE_W-1:0] filtered_drive;
      logic [POS_W-1:0]          rotor_position;
      logic                      outputs_on;
      logic [DUTY_W-1:0]         duty_g;
      logic [DUTY_W-1:0]         duty_b;
      logic [DUTY_W-1:0]         duty_y;
   } commutation_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [PERIOD_W-1:0]   csr_data;

   // Predictor state
   logic                     drive_on;
   logic [PERIOD_W-1:0]      period_reg;
   logic signed [ACC_W-1:0]  filter_acc;
   logic [POS_W-1:0]         last_position;
   logic [SPEED_W-1:0]       tick_count;
   logic [SPEED_W-1:0]       speed_capture;

   commutation_type pending_results[$];
   int           mismatch_count;
   int           cycle_count;
   int           sender_idle_pct;
   int           rsp_idle_pct;
   int           stall_left;

   hall_six_step_commutator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Hall code a + 2b + 4c to six-step position
   function automatic logic [POS_W-1:0] decode_hall(input logic [2:0] code);
      case (code)
         3'd4:    return POS_1;
         3'd5:    return POS_2;
         3'd1:    return POS_3;
         3'd3:    return POS_4;
         3'd2:    return POS_5;
         3'd6:    return POS_6;
         default: return POS_NONE;
      endcase
   endfunction

   // Position back to the hall code that produces it
   function automatic logic [2:0] hall_for_position(input int pos);
      case (pos)
         1:       return 3'd4;
         2:       return 3'd5;
         3:       return 3'd1;
         4:       return 3'd3;
         5:       return 3'd2;
         default: return 3'd6;
      endcase
   endfunction

   // Midpoint offset, then clamp to floor .. max(period - floor, floor)
   function automatic logic [DUTY_W-1:0] compare_value(input int drive);
      int top;
      int v;
      top = int'(period_reg) - DUTY_FLOOR;
      if (top < DUTY_FLOOR) top = DUTY_FLOOR;
      v = drive + int'(period_reg >> 1);
      if (v < DUTY_FLOOR) v = DUTY_FLOOR;
      if (v > top) v = top;
      return DUTY_W'(v);
   endfunction

   function automatic int held_drive();
      int f;
      f = int'(filter_acc) >>> LPF_SHIFT;
      if (f > DRIVE_LIMIT) f = DRIVE_LIMIT;
      if (f < -DRIVE_LIMIT) f = -DRIVE_LIMIT;
      return f;
   endfunction

   // Advance the commutation state by one sample and give its result
   function automatic commutation_type predict_commutation(input hall_sample_type s);
      commutation_type r;
      logic [POS_W-1:0] pos;
      int sp;
      int acc;
      int f;
      int y;
      int b;
      int g;
      pos = decode_hall({s.hall_c, s.hall_b, s.hall_a});
      r = '0;
      if (drive_on) begin
         sp = int'(s.setpoint);
         if (sp > DRIVE_LIMIT) sp = DRIVE_LIMIT;
         if (sp < -DRIVE_LIMIT) sp = -DRIVE_LIMIT;
         acc = int'(filter_acc);
         acc = acc - (acc >>> LPF_SHIFT) + sp;
         if (acc > ACC_HI) acc = ACC_HI;
         if (acc < ACC_LO) acc = ACC_LO;
         filter_acc = ACC_W'(acc);
         f = held_drive();
         y = 0;
         b = 0;
         g = 0;
         case (pos)
            POS_1: begin b = f;  g = -f; end
            POS_2: begin y = -f; b = f;  end
            POS_3: begin y = -f; g = f;  end
            POS_4: begin b = -f; g = f;  end
            POS_5: begin y = f;  b = -f; end
            POS_6: begin y = f;  g = -f; end
            default: ;
         endcase
         r.duty_y     = compare_value(y);
         r.duty_b     = compare_value(b);
         r.duty_g     = compare_value(g);
         r.outputs_on = 1'b1;
         // Speed capture on entry into position 1
         if (last_position != POS_1 && pos == POS_1) begin
            speed_capture = tick_count;
            tick_count    = '0;
         end
         last_position = pos;
         if (tick_count != {SPEED_W{1'b1}}) tick_count = tick_count + 1'b1;
      end
      r.rotor_position = pos;
      r.filtered_drive = DRIVE_W'(held_drive());
      r.speed_period   = speed_capture;
      return r;
   endfunction

   function automatic string describe(input commutation_type r);
      return $sformatf("y=%0d b=%0d g=%0d on=%0b pos=%0d drive=%0d speed=%0d",
                       r.duty_y, r.duty_b, r.duty_g, r.outputs_on, r.rotor_position,
                       r.filtered_drive, r.speed_period);
   endfunction

   // Result checker
   always @(posedge clock) begin
      commutation_type got;
      commutation_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(commutation_type)-1:0];
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10) $display("unexpected result: %s", describe(got));
            mismatch_count = mismatch_count + 1;
         end else begin
            want = pending_results.pop_front();
            if (got.duty_y !== want.duty_y || got.duty_b !== want.duty_b ||
                got.duty_g !== want.duty_g || got.outputs_on !== want.outputs_on ||
                got.rotor_position !== want.rotor_position ||
                got.filtered_drive !== want.filtered_drive ||
                got.speed_period !== want.speed_period) begin
               if (mismatch_count < 10) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // Result receiver: random idling plus a forced hold-off
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Entered and left at a falling edge
   task automatic send_sample(input hall_sample_type s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_DATA_W'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_commutation(s));
      @(negedge clock);
   endtask

   task automatic send_hall(input logic [2:0] code, input logic signed [SETPOINT_W-1:0] sp);
      hall_sample_type s;
      s.hall_a   = code[0];
      s.hall_b   = code[1];
      s.hall_c   = code[2];
      s.setpoint = sp;
      send_sample(s);
   endtask

   // Register write once the block has drained
   task automatic csr_write(input logic index, input logic [PERIOD_W-1:0] value);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_DRIVE_ENABLE) drive_on = value[0];
      else period_reg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic hall_sample_type random_sample();
      return hall_sample_type'(SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1)));
   endfunction

   function automatic logic signed [SETPOINT_W-1:0] pick_setpoint();
      case ($urandom_range(7))
         0, 1:    return SETPOINT_W'(DRIVE_LIMIT);
         2, 3:    return SETPOINT_W'(-DRIVE_LIMIT);
         4:       return SETPOINT_W'($urandom_range(2400) - 1200);
         5:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         6:       return SETPOINT_W'($urandom_range(65535));
         default: return '0;
      endcase
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(4))
         0:       return PERIOD_W'(20);
         1:       return PERIOD_W'(4095);
         2:       return PERIOD_W'($urandom_range(120, 20));
         default: return PERIOD_W'($urandom_range(4095, 20));
      endcase
   endfunction

   // Disabled after reset: zero duties, decoded position, state held
   task automatic test_disabled_outputs();
      send_hall(3'd4, 16'sh7FFF);
      send_hall(3'd7, 16'sh8000);
   endtask

   // Every hall code, setpoint clamp edges, entry into position 1
   task automatic test_commutation_table();
      csr_write(REG_PWM_PERIOD, PERIOD_W'(2000));
      csr_write(REG_DRIVE_ENABLE, 1'b1);
      for (int code = 0; code < 8; code++) send_hall(3'(code), 16'sh7FFF);
      send_hall(3'd4, 16'sd1001);
      send_hall(3'd4, 16'sd1000);
      send_hall(3'd2, -16'sd1001);
      send_hall(3'd4, -16'sd1000);
      send_hall(3'd6, 16'sh8000);
   endtask

   // Smallest period pins every duty to the floor; odd largest period
   task automatic test_period_extremes();
      csr_write(REG_PWM_PERIOD, PERIOD_W'(20));
      send_hall(3'd4, 16'sh7FFF);
      send_hall(3'd1, 16'sh8000);
      csr_write(REG_PWM_PERIOD, PERIOD_W'(4095));
      send_hall(3'd5, 16'sh7FFF);
      send_hall(3'd3, 16'sh8000);
      send_hall(3'd0, 16'sd0);
   endtask

   // Long receiver hold-off while items keep coming, so req_tready drops
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      stall_left      = 300;
      for (int i = 0; i < 12; i++) send_hall(hall_for_position(i % 6 + 1), pick_setpoint());
   endtask

   // Rotating hall sequences with held setpoints, plus noise and glitches
   task automatic test_random_rotation(input int n_items, input int send_pct,
                                       input int recv_pct);
      int sent;
      int pos;
      int dwell;
      int run_len;
      int forward;
      logic signed [SETPOINT_W-1:0] target;
      hall_sample_type s;
      sender_idle_pct = send_pct;
      rsp_idle_pct    = recv_pct;
      sent = 0;
      pos  = $urandom_range(6, 1);
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) csr_write(REG_PWM_PERIOD, pick_period());
         if ($urandom_range(14) == 0) begin
            csr_write(REG_DRIVE_ENABLE, 1'b0);
            repeat ($urandom_range(6, 1)) send_sample(random_sample());
            csr_write(REG_DRIVE_ENABLE, 1'b1);
         end
         if ($urandom_range(4) == 0) begin
            // noise: arbitrary codes and setpoints
            repeat ($urandom_range(10, 1)) begin
               send_sample(random_sample());
               sent++;
            end
         end else begin
            target  = pick_setpoint();
            forward = $urandom_range(1);
            run_len = ($urandom_range(7) == 0) ? $urandom_range(600, 300)
                                               : $urandom_range(120, 20);
            dwell   = $urandom_range(8, 1);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
               if ($urandom_range(29) == 0) begin
                  // sensor glitch
                  s = random_sample();
               end else begin
                  s.setpoint = ($urandom_range(5) == 0) ? pick_setpoint() : target;
                  {s.hall_c, s.hall_b, s.hall_a} = hall_for_position(pos);
               end
               send_sample(s);
               sent++;
               dwell--;
               if (dwell == 0) begin
                  dwell = $urandom_range(8, 1);
                  if (forward) pos = pos % 6 + 1;
                  else pos = (pos == 1) ? 6 : pos - 1;
               end
            end
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_index       = REG_DRIVE_ENABLE;
      csr_data        = '0;
      mismatch_count  = 0;
      cycle_count     = 0;
      stall_left      = 0;
      sender_idle_pct = 28;
      rsp_idle_pct    = 53;
      drive_on        = 1'b0;
      period_reg      = PERIOD_W'(2000);
      filter_acc      = '0;
      last_position   = POS_NONE;
      tick_count      = '0;
      speed_capture   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_outputs();
      test_commutation_table();
      test_period_extremes();
      test_random_rotation(370, 28, 53);
      test_random_rotation(370, 53, 28);
      test_random_rotation(370, 0, 0);
      test_output_backpressure();

      // Drain
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
